FILE: src/ppla_pkg.sv
package ppla_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_ATOMS   = 1024;
  localparam int unsigned DEF_COORD_WIDTH = 24;

  // Fixed field widths.
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned CTR_W     = 24;
  localparam int unsigned RAD_LIM_W = 23;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PATH_W    = 40;

  // Register reset values.
  localparam logic [CTR_W-1:0]     CENTER_RST = 24'd12800;
  localparam logic [RAD_LIM_W-1:0] RADIUS_RST = 23'd8448;

  // Largest path total.
  localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

  // Item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_idx_e;

  // Operations handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_QUERY,
    OP_QUERY_NULL,
    OP_STORE,
    OP_UPDATE
  } op_e;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_ROOT,
    ST_FIN,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

FILE: src/ppla_if.sv
interface ppla_item_if #(
  parameter int unsigned COORD_WIDTH = ppla_pkg::DEF_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic                          first_frame;
  logic [ppla_pkg::IDX_W-1:0]    atom_index;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source (output valid, kind, first_frame, atom_index, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, kind, first_frame, atom_index, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface ppla_result_if;
  logic                        valid;
  logic                        ready;
  logic [ppla_pkg::IDX_W-1:0]  result_atom;
  logic [ppla_pkg::PATH_W-1:0] path_length;
  logic                        excluded;

  modport source (output valid, result_atom, path_length, excluded, input ready);
  modport sink (input valid, result_atom, path_length, excluded, output ready);
endinterface

FILE: src/ppla_ram.sv
module ppla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ppla_front.sv
module ppla_front #(
  parameter int unsigned MAX_ATOMS   = ppla_pkg::DEF_MAX_ATOMS,
  parameter int unsigned COORD_WIDTH = ppla_pkg::DEF_COORD_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ppla_item_if.sink                    item_i,
  input  ppla_pkg::back_stat_t         stat_i,
  output logic                         head_valid_o,
  output ppla_pkg::cmd_t               head_cmd_o,
  output logic [3*COORD_WIDTH-1:0]     head_pos_o
);
  import ppla_pkg::*;

  localparam int unsigned PW = 3 * COORD_WIDTH;

  cmd_t            cmd_q [2];
  logic [PW-1:0]   pos_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            accept, push, idx_ok;
  cmd_t            cmd_in;

  // Take no request while the back end sweeps its memory or the queue is full.
  assign item_i.ready = !stat_i.clearing && (cnt_q != 2'd2);
  assign accept       = item_i.valid && item_i.ready;

  // Classify the request; samples for atoms out of range are dropped here.
  assign idx_ok = 32'(item_i.atom_index) < MAX_ATOMS;

  always_comb begin
    cmd_in.idx = item_i.atom_index;
    if (item_i.kind == KIND_QUERY) begin
      cmd_in.op = idx_ok ? OP_QUERY : OP_QUERY_NULL;
    end else if (item_i.first_frame) begin
      cmd_in.op = OP_STORE;
    end else begin
      cmd_in.op = OP_UPDATE;
    end
  end

  assign push = accept && ((item_i.kind == KIND_QUERY) || idx_ok);

  // Two-entry queue payload.
  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wptr_q] <= cmd_in;
      pos_q[wptr_q] <= {item_i.pos_x, item_i.pos_y, item_i.pos_z};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (stat_i.pop) begin
        rptr_q <= !rptr_q;
      end
      if (push && !stat_i.pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!push && stat_i.pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign head_valid_o = (cnt_q != 2'd0);
  assign head_cmd_o   = cmd_q[rptr_q];
  assign head_pos_o   = pos_q[rptr_q];

endmodule

FILE: src/ppla_back.sv
module ppla_back #(
  parameter int unsigned MAX_ATOMS   = ppla_pkg::DEF_MAX_ATOMS,
  parameter int unsigned COORD_WIDTH = ppla_pkg::DEF_COORD_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ppla_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppla_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           head_valid_i,
  input  ppla_pkg::cmd_t                 head_cmd_i,
  input  logic [3*COORD_WIDTH-1:0]       head_pos_i,
  output ppla_pkg::back_stat_t           stat_o,
  ppla_result_if.source                  result_o
);
  import ppla_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned PW     = 3 * CW;
  localparam int unsigned AW     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned MW     = (CW > CTR_W) ? CW : CTR_W;
  localparam int unsigned ACC_P  = 2 * CW + 2;
  localparam int unsigned ACC_C  = 2 * MW + 2;
  localparam int unsigned RAD_W  = (ACC_P > 64) ? 64 : ACC_P;
  localparam int unsigned ROOT_W = (RAD_W + 1) / 2;
  localparam int unsigned RADE_W = 2 * ROOT_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);
  localparam int unsigned REC_W  = PATH_W + 1;
  localparam logic [ACC_P-1:0] SAT_LIM = ACC_P'({64{1'b1}});

  state_e state_q, state_d;

  // Configuration registers.
  logic [CTR_W-1:0]     cx_q, cy_q, cz_q;
  logic [RAD_LIM_W-1:0] rad_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q      <= CENTER_RST;
      cy_q      <= CENTER_RST;
      cz_q      <= CENTER_RST;
      rad_lim_q <= RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X: cx_q <= cfg_data_i;
        REG_CENTER_Y: cy_q <= cfg_data_i;
        REG_CENTER_Z: cz_q <= cfg_data_i;
        REG_RADIUS:   rad_lim_q <= cfg_data_i[RAD_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers.
  cmd_t                 cmd_q;
  logic [PW-1:0]        cur_q, prev_q;
  logic [PATH_W-1:0]    path_q;
  logic                 flag_q;
  logic [2:0]           step_q;
  logic [2*MW-1:0]      prod_q;
  logic [ACC_P-1:0]     acc_p_q;
  logic [ACC_C-1:0]     acc_c_q;
  logic [2*RAD_LIM_W-1:0] rr_q;
  logic [RADE_W-1:0]    rad_q;
  logic [REM_W-1:0]     rem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [AW-1:0]        clr_q;

  // Output register.
  logic                 out_valid_q;
  logic [IDX_W-1:0]     out_atom_q;
  logic [PATH_W-1:0]    out_path_q;
  logic                 out_excl_q;
  logic                 out_free;

  // Memory ports.
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 prev_we, path_we;
  logic [AW-1:0]        path_waddr;
  logic [REC_W-1:0]     path_wdata;
  logic [PW-1:0]        prev_rd;
  logic [REC_W-1:0]     path_rd;

  ppla_ram #(.WIDTH(PW), .DEPTH(MAX_ATOMS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (AW'(cmd_q.idx)),
    .wdata_i (cur_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (prev_rd)
  );

  ppla_ram #(.WIDTH(REC_W), .DEPTH(MAX_ATOMS)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (path_we),
    .waddr_i (path_waddr),
    .wdata_i (path_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (path_rd)
  );

  // Squarer operand, one per step: move and centre deltas, then radius.
  logic signed [MW:0] op_a, op_b, diff;
  logic [MW-1:0]      mul_a;

  always_comb begin
    case (step_q)
      3'd0: begin
        op_a = (MW+1)'(signed'(cur_q[3*CW-1 -: CW]));
        op_b = (MW+1)'(signed'(prev_q[3*CW-1 -: CW]));
      end
      3'd1: begin
        op_a = (MW+1)'(signed'(cur_q[2*CW-1 -: CW]));
        op_b = (MW+1)'(signed'(prev_q[2*CW-1 -: CW]));
      end
      3'd2: begin
        op_a = (MW+1)'(signed'(cur_q[CW-1:0]));
        op_b = (MW+1)'(signed'(prev_q[CW-1:0]));
      end
      3'd3: begin
        op_a = (MW+1)'(signed'(cur_q[3*CW-1 -: CW]));
        op_b = (MW+1)'(signed'(cx_q));
      end
      3'd4: begin
        op_a = (MW+1)'(signed'(cur_q[2*CW-1 -: CW]));
        op_b = (MW+1)'(signed'(cy_q));
      end
      3'd5: begin
        op_a = (MW+1)'(signed'(cur_q[CW-1:0]));
        op_b = (MW+1)'(signed'(cz_q));
      end
      default: begin
        op_a = signed'((MW+1)'(rad_lim_q));
        op_b = '0;
      end
    endcase
    diff  = op_a - op_b;
    mul_a = diff[MW] ? MW'(-diff) : MW'(diff);
  end

  // One root digit per cycle, restoring form.
  logic [REM_W+1:0] cand, sub;
  logic             ge;

  assign cand = {rem_q, rad_q[RADE_W-1 -: 2]};
  assign sub  = (REM_W+2)'({root_q, 2'b01});
  assign ge   = cand >= sub;

  // Path update and sphere test for the final write.
  logic [PATH_W:0]   path_sum;
  logic [PATH_W-1:0] path_new;
  logic              flag_new;

  assign path_sum = {1'b0, path_q} + (PATH_W+1)'(root_q);
  assign path_new = path_sum[PATH_W] ? PATH_MAX : path_sum[PATH_W-1:0];
  assign flag_new = flag_q || (acc_c_q > ACC_C'(rr_q));

  assign out_free = !out_valid_q || result_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == AW'(MAX_ATOMS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (head_valid_i) state_d = ST_LOAD;
      ST_LOAD: begin
        case (cmd_q.op)
          OP_QUERY, OP_QUERY_NULL: state_d = ST_RESP;
          OP_UPDATE:               state_d = ST_SQ;
          default:                 state_d = ST_IDLE;
        endcase
      end
      ST_SQ:   if (step_q == 3'd7) state_d = ST_ROOT;
      ST_ROOT: if (cnt_q == CNT_W'(ROOT_W - 1)) state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      ST_RESP: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    stat_o.clearing = (state_q == ST_CLEAR);
    stat_o.pop      = (state_q == ST_IDLE) && head_valid_i;
    rd_en           = stat_o.pop;
    rd_addr         = AW'(head_cmd_i.idx);
    prev_we         = ((state_q == ST_LOAD) && (cmd_q.op == OP_STORE)) || (state_q == ST_FIN);
    path_we         = (state_q == ST_CLEAR) || (state_q == ST_FIN);
    path_waddr      = (state_q == ST_CLEAR) ? clr_q : AW'(cmd_q.idx);
    path_wdata      = (state_q == ST_CLEAR) ? '0 : {flag_new, path_new};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Control counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      step_q <= (state_q == ST_SQ) ? step_q + 3'd1 : 3'd0;
      cnt_q  <= (state_q == ST_ROOT) ? cnt_q + CNT_W'(1) : '0;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (stat_o.pop) begin
      cmd_q <= head_cmd_i;
      cur_q <= head_pos_i;
    end
    if (state_q == ST_LOAD) begin
      prev_q <= prev_rd;
      path_q <= path_rd[PATH_W-1:0];
      flag_q <= path_rd[PATH_W];
    end
    if (state_q == ST_SQ) begin
      prod_q <= mul_a * mul_a;
      case (step_q)
        3'd0: begin
          acc_p_q <= '0;
          acc_c_q <= '0;
        end
        3'd1, 3'd2, 3'd3: acc_p_q <= acc_p_q + ACC_P'(prod_q[2*CW-1:0]);
        3'd4, 3'd5, 3'd6: acc_c_q <= acc_c_q + ACC_C'(prod_q);
        default: begin
          rr_q   <= prod_q[2*RAD_LIM_W-1:0];
          rem_q  <= '0;
          root_q <= '0;
          if (ACC_P > 64 && acc_p_q > SAT_LIM) begin
            rad_q <= '1;
          end else begin
            rad_q <= RADE_W'(acc_p_q);
          end
        end
      endcase
    end
    if (state_q == ST_ROOT) begin
      rem_q  <= ge ? REM_W'(cand - sub) : REM_W'(cand);
      root_q <= {root_q[ROOT_W-2:0], ge};
      rad_q  <= rad_q << 2;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_RESP) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESP) && out_free) begin
      out_atom_q <= cmd_q.idx;
      out_path_q <= (cmd_q.op == OP_QUERY) ? path_q : '0;
      out_excl_q <= (cmd_q.op == OP_QUERY) && flag_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.result_atom = out_atom_q;
  assign result_o.path_length = out_path_q;
  assign result_o.excluded    = out_excl_q;

endmodule

FILE: src/particle_path_length_accumulator.sv
// Channel   Dir  Payload
// item_i    in   kind, first_frame, atom_index, pos_x, pos_y, pos_z
// result_o  out  result_atom, path_length, excluded
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// A later-frame sample runs eight squarer steps and then the bit-serial
// square root; first-frame samples and queries skip both. After reset
// the block sweeps the path memory and takes no request until that is
// done. A two-entry queue and the result register let input and output
// stall independently.
module particle_path_length_accumulator #(
  parameter int unsigned MAX_ATOMS   = ppla_pkg::DEF_MAX_ATOMS,
  parameter int unsigned COORD_WIDTH = ppla_pkg::DEF_COORD_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ppla_item_if.sink                      item_i,
  ppla_result_if.source                  result_o,
  input  logic                           cfg_we_i,
  input  logic [ppla_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppla_pkg::CFG_W-1:0]     cfg_data_i
);
  import ppla_pkg::*;

  back_stat_t                stat;
  logic                      head_valid;
  cmd_t                      head_cmd;
  logic [3*COORD_WIDTH-1:0]  head_pos;

  ppla_front #(.MAX_ATOMS(MAX_ATOMS), .COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .stat_i       (stat),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .head_pos_o   (head_pos)
  );

  ppla_back #(.MAX_ATOMS(MAX_ATOMS), .COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .head_pos_i   (head_pos),
    .stat_o       (stat),
    .result_o     (result_o)
  );

endmodule

FILE: test/particle_path_length_accumulator_tb.sv
module particle_path_length_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppla_pkg::*;

  localparam int unsigned COORD_W     = DEF_COORD_WIDTH;
  localparam int unsigned ATOMS       = DEF_MAX_ATOMS;
  localparam int unsigned SETTLE      = 200;
  localparam longint      CYCLE_LIMIT = 4000000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [IDX_W-1:0]  atom;
    logic [PATH_W-1:0] path;
    logic              excl;
  } path_report_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  ppla_item_if #(.COORD_WIDTH(COORD_W)) item_ch ();
  ppla_result_if res_ch ();

  particle_path_length_accumulator #(
    .MAX_ATOMS(ATOMS),
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .item_i(item_ch),
    .result_o(res_ch),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predictor state: one copy of the block's per-atom memories and registers.
  coord_t prev_x [ATOMS];
  coord_t prev_y [ATOMS];
  coord_t prev_z [ATOMS];
  bit placed [ATOMS];
  logic [PATH_W-1:0] path_sum [ATOMS];
  logic left_sphere [ATOMS];
  coord_t ctr_x, ctr_y, ctr_z;
  logic [RAD_LIM_W-1:0] radius;

  path_report_t expected_reports [$];
  int unsigned mismatches;
  longint cycles;
  bit no_gaps;

  // Atoms used by the random phases.
  logic [IDX_W-1:0] atom_pool [16];

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic longint unsigned squared_span(coord_t ax, coord_t ay, coord_t az,
                                                   coord_t bx, coord_t by, coord_t bz);
    longint signed dx, dy, dz;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
  endfunction

  // Bit-by-bit integer square root, truncated toward zero.
  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res;
    longint unsigned bit_v;
    res = 0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // Applies one accepted request to the predictor, queuing any report it causes.
  task automatic track_request(logic kind, logic first, logic [IDX_W-1:0] idx,
                               coord_t x, coord_t y, coord_t z);
    path_report_t rep;
    longint unsigned step;
    longint unsigned total;
    longint unsigned lim;
    if (kind == KIND_QUERY) begin
      rep.atom = idx;
      rep.path = path_sum[idx];
      rep.excl = left_sphere[idx];
      expected_reports.push_back(rep);
    end else begin
      if (first == 1'b0) begin
        step = int_root(squared_span(x, y, z, prev_x[idx], prev_y[idx], prev_z[idx]));
        total = longint'(path_sum[idx]) + step;
        path_sum[idx] = (total > longint'(PATH_MAX)) ? PATH_MAX : total[PATH_W-1:0];
        lim = longint'(radius);
        if (squared_span(x, y, z, ctr_x, ctr_y, ctr_z) > lim * lim)
          left_sphere[idx] = 1'b1;
      end
      prev_x[idx] = x;
      prev_y[idx] = y;
      prev_z[idx] = z;
      placed[idx] = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sends one request, with a random gap ahead of it unless gaps are off.
  task automatic send_request(logic kind, logic first, logic [IDX_W-1:0] idx,
                              coord_t x, coord_t y, coord_t z);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind <= kind;
    item_ch.first_frame <= first;
    item_ch.atom_index <= idx;
    item_ch.pos_x <= x;
    item_ch.pos_y <= y;
    item_ch.pos_z <= z;
    do @(posedge clk_i); while (!item_ch.ready);
    track_request(kind, first, idx, x, y, z);
  endtask

  // Lowers valid and waits until every report has come and the block settles.
  task automatic drain;
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Writes all four registers on consecutive cycles while the block is idle.
  task automatic write_registers(coord_t cx, coord_t cy, coord_t cz,
                                 logic [RAD_LIM_W-1:0] r);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_CENTER_X;
    cfg_data_i <= cx;
    @(posedge clk_i);
    cfg_idx_i <= REG_CENTER_Y;
    cfg_data_i <= cy;
    @(posedge clk_i);
    cfg_idx_i <= REG_CENTER_Z;
    cfg_data_i <= cz;
    @(posedge clk_i);
    cfg_idx_i <= REG_RADIUS;
    cfg_data_i <= {1'b0, r};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ctr_x = cx;
    ctr_y = cy;
    ctr_z = cz;
    radius = r;
  endtask

  // Result side: random stall per report, then compare with the oldest expectation.
  initial begin
    path_report_t want;
    int unsigned stall;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report for atom", res_ch.result_atom, -1);
      end else begin
        want = expected_reports.pop_front();
        if (res_ch.result_atom !== want.atom)
          report_mismatch("result_atom", res_ch.result_atom, want.atom);
        if (res_ch.path_length !== want.path)
          report_mismatch("path_length", res_ch.path_length, want.path);
        if (res_ch.excluded !== want.excl)
          report_mismatch("excluded", res_ch.excluded, want.excl);
      end
    end
  end

  // Directed requests: extremes, queries, sphere boundary.
  task automatic test_directed;
    coord_t lo, hi;
    lo = {1'b1, {(COORD_W-1){1'b0}}};
    hi = {1'b0, {(COORD_W-1){1'b1}}};
    // Query of atom 0; on the first run it is untouched and reads zero.
    send_request(KIND_QUERY, 1'b0, 10'd0, 0, 0, 0);
    send_request(KIND_QUERY, 1'b1, 10'd1023, hi, lo, hi);
    // Opposite corners of the coordinate space.
    send_request(KIND_SAMPLE, 1'b1, 10'd1023, lo, lo, lo);
    send_request(KIND_SAMPLE, 1'b0, 10'd1023, hi, hi, hi);
    send_request(KIND_SAMPLE, 1'b0, 10'd1023, lo, hi, lo);
    send_request(KIND_QUERY, 1'b1, 10'd1023, lo, lo, lo);
    // Re-storing a first frame drops the old position, not the total.
    send_request(KIND_SAMPLE, 1'b1, 10'd1023, 0, 0, 0);
    send_request(KIND_SAMPLE, 1'b0, 10'd1023, 24'sd1, 24'sd1, 24'sd1);
    send_request(KIND_QUERY, 1'b0, 10'd1023, 0, 0, 0);
    // Exactly on the sphere stays inside, one step further is out.
    send_request(KIND_SAMPLE, 1'b1, 10'd2, ctr_x, ctr_y, ctr_z);
    send_request(KIND_SAMPLE, 1'b0, 10'd2, ctr_x + coord_t'(radius), ctr_y, ctr_z);
    send_request(KIND_QUERY, 1'b0, 10'd2, 0, 0, 0);
    send_request(KIND_SAMPLE, 1'b0, 10'd2, ctr_x + coord_t'(radius) + 24'sd1, ctr_y, ctr_z);
    send_request(KIND_QUERY, 1'b0, 10'd2, 0, 0, 0);
    // Back inside: the flag stays set.
    send_request(KIND_SAMPLE, 1'b0, 10'd2, ctr_x, ctr_y, ctr_z);
    send_request(KIND_QUERY, 1'b0, 10'd2, 0, 0, 0);
    // Sub-unit step truncates.
    send_request(KIND_SAMPLE, 1'b1, 10'd3, 24'sd0, 24'sd0, 24'sd0);
    send_request(KIND_SAMPLE, 1'b0, 10'd3, 24'sd1, 24'sd1, 24'sd0);
    send_request(KIND_QUERY, 1'b0, 10'd3, 0, 0, 0);
  endtask

  // Drives one atom back and forth between far corners so its total grows in large steps.
  task automatic test_long_path;
    coord_t lo, hi;
    lo = {1'b1, {(COORD_W-1){1'b0}}};
    hi = {1'b0, {(COORD_W-1){1'b1}}};
    no_gaps = 1'b1;
    send_request(KIND_SAMPLE, 1'b1, 10'd700, lo, lo, lo);
    for (int i = 0; i < 200; i++) begin
      if (i % 2 == 0) send_request(KIND_SAMPLE, 1'b0, 10'd700, hi, hi, hi);
      else send_request(KIND_SAMPLE, 1'b0, 10'd700, lo, lo, lo);
      if (i == 100) send_request(KIND_QUERY, 1'b0, 10'd700, 0, 0, 0);
    end
    send_request(KIND_QUERY, 1'b0, 10'd700, 0, 0, 0);
    no_gaps = 1'b0;
  endtask

  function automatic coord_t pick_coord(coord_t centre);
    int unsigned mode;
    int signed offs;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      offs = int'($urandom_range(0, 2 * radius + 128)) - int'(radius) - 64;
      return centre + coord_t'(offs);
    end else if (mode < 9) begin
      return coord_t'($urandom());
    end else begin
      return $urandom_range(0, 1) ? {1'b1, {(COORD_W-1){1'b0}}}
                                  : {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  // Random trajectories on a small pool of atoms, queries mixed in.
  task automatic test_random_phase(int unsigned count);
    logic [IDX_W-1:0] idx;
    logic first;
    foreach (atom_pool[i]) atom_pool[i] = IDX_W'($urandom_range(0, ATOMS - 1));
    atom_pool[0] = 10'd0;
    atom_pool[1] = 10'd1023;
    for (int unsigned n = 0; n < count; n++) begin
      idx = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, ATOMS - 1))
                                         : atom_pool[$urandom_range(0, 15)];
      if ($urandom_range(0, 3) == 0) begin
        send_request(KIND_QUERY, 1'($urandom()), idx, coord_t'($urandom()),
                     coord_t'($urandom()), coord_t'($urandom()));
      end else begin
        first = !placed[idx] || ($urandom_range(0, 19) == 0);
        send_request(KIND_SAMPLE, first, idx, pick_coord(ctr_x), pick_coord(ctr_y),
                     pick_coord(ctr_z));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cycles = 0;
    mismatches = 0;
    no_gaps = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_CENTER_X;
    cfg_data_i = '0;
    item_ch.valid = 1'b0;
    item_ch.kind = KIND_SAMPLE;
    item_ch.first_frame = 1'b0;
    item_ch.atom_index = '0;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.pos_z = '0;
    ctr_x = CENTER_RST;
    ctr_y = CENTER_RST;
    ctr_z = CENTER_RST;
    radius = RADIUS_RST;
    for (int i = 0; i < ATOMS; i++) begin
      prev_x[i] = '0;
      prev_y[i] = '0;
      prev_z[i] = '0;
      placed[i] = 1'b0;
      path_sum[i] = '0;
      left_sphere[i] = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_long_path();
    test_random_phase(450);
    write_registers(24'sh800000, 24'sh7fffff, 24'sd0, 23'd0);
    test_directed();
    test_random_phase(350);
    write_registers(24'sh7fffff, 24'sh800000, 24'sh7fffff, 23'h7fffff);
    test_random_phase(350);
    write_registers(-24'sd5000, 24'sd300, 24'sd77, 23'd20000);
    test_random_phase(600);
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
src/ppla_pkg.sv
src/ppla_if.sv
src/ppla_ram.sv
src/ppla_front.sv
src/ppla_back.sv
src/particle_path_length_accumulator.sv
test/particle_path_length_accumulator_tb.sv
